// File: src/rle_pkg.sv
// shared types and constants of the run-length byte encoder
package rle_pkg;

  localparam logic [1:0] CMD_PUSH       = 2'd0;
  localparam logic [1:0] CMD_PUSH_CLOSE = 2'd1;

  localparam logic [7:0] END_MARKER   = 8'h80;
  localparam logic [8:0] REP_HDR_BASE = 9'd257;

  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] data_byte;
  } in_t;

  typedef struct packed {
    logic [63:0] out_bytes;
    logic [3:0]  byte_count;
    logic        last_of_burst;
    logic        stream_end;
  } out_t;

  // one encoded byte on its way from the sequencer to the packer
  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       end_mark;
  } rle_byte_t;

endpackage

// File: src/run_length_byte_encoder.sv
// top level of the streaming run-length (packbits style) byte encoder
//
// input channel: one word per raw byte, cmd selects push, push and close, or close only
// output channel: encoded bytes packed up to eight per word, first byte in bits 7:0,
//   with a count, a flag on the final word of each input's burst and a flag on
//   the word that carries the end marker
// an input word that produces no encoded bytes leaves the block idle; ready is high
//   again in the next cycle
// an input word that produces n encoded bytes (a flushed run, a flushed literal,
//   or the close burst) holds off the next input word until all n have left:
//   the sequencer emits one byte per cycle while the packer accepts and reads
//   the literal store one entry per byte; a close burst is at most MAX_RUN + 4 bytes
// the first output word of a burst appears after the input word, once eight
//   bytes or the burst's final byte have reached the packer
// a stalled receiver holds the packer's output register, which in turn stalls
//   the byte sequencer; nothing is dropped and input waits meanwhile
// reset (synchronous, active low) returns to an empty stream; the literal store
//   needs no clearing since only entries written in the open literal are read
module run_length_byte_encoder #(
  parameter int MAX_RUN = 128
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  rle_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output rle_pkg::out_t out_data
);

  localparam int CW = $clog2(MAX_RUN + 1);
  localparam int AW = $clog2(MAX_RUN);
  localparam logic [CW-1:0] MAX_C = CW'(MAX_RUN);

  typedef enum logic [3:0] {
    S_IDLE,
    S_REPA_H,
    S_REPA_V,
    S_LIT_H,
    S_LIT_M,
    S_LIT_T,
    S_LIT2_H,
    S_LIT2_T,
    S_REPB_H,
    S_REPB_V,
    S_END
  } state_t;

  // segments one input word releases, always sent in this order
  typedef struct packed {
    logic          repa_v;
    logic [CW-1:0] repa_cnt;
    logic [7:0]    repa_val;
    logic          lit_v;     // literal from the store, optionally ended by the tail byte
    logic [CW-1:0] lit_m;
    logic          lit_t;
    logic          lit2_v;    // single-byte literal holding only the tail byte
    logic          repb_v;
    logic [CW-1:0] repb_cnt;
    logic [7:0]    repb_val;
    logic          end_v;
    logic [7:0]    tail;
  } plan_t;

  function automatic state_t seg_from(input logic a, input logic l, input logic l2,
                                      input logic b, input logic e);
    state_t s;
    if (a) begin
      s = S_REPA_H;
    end else if (l) begin
      s = S_LIT_H;
    end else if (l2) begin
      s = S_LIT2_H;
    end else if (b) begin
      s = S_REPB_H;
    end else if (e) begin
      s = S_END;
    end else begin
      s = S_IDLE;
    end
    return s;
  endfunction

  // encoder state
  state_t        st_r, st_nxt;
  logic [AW-1:0] k_r, k_nxt;
  plan_t         plan_r, plan_nxt, plan_new;
  logic          run_act_r, run_act_nxt;
  logic [7:0]    run_val_r, run_val_nxt;
  logic [CW-1:0] run_cnt_r, run_cnt_nxt;
  logic          look_v_r, look_v_nxt;
  logic [7:0]    look_b_r, look_b_nxt;
  logic [CW-1:0] lit_cnt_r, lit_cnt_nxt;

  logic          in_fire;
  logic          is_push;
  logic          is_close;
  logic [7:0]    b;

  // literal store ports
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [7:0]    wr_data;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic [7:0]    rd_data;

  // sequencer to packer
  rle_pkg::rle_byte_t seq_byte;
  logic               seq_valid;
  logic               seq_ready;
  logic               emit;
  state_t             follow;
  logic [AW-1:0]      k_follow;
  state_t             after_repa, after_lit, after_lit2, after_repb;

  // input side: decide what the word does to the run, lookahead and literal
  always_comb begin
    in_ready = (st_r == S_IDLE);
    in_fire  = in_valid && in_ready;
    b        = in_data.data_byte;
    is_push  = (in_data.cmd == rle_pkg::CMD_PUSH) || (in_data.cmd == rle_pkg::CMD_PUSH_CLOSE);
    is_close = (in_data.cmd != rle_pkg::CMD_PUSH);

    run_act_nxt = run_act_r;
    run_val_nxt = run_val_r;
    run_cnt_nxt = run_cnt_r;
    look_v_nxt  = look_v_r;
    look_b_nxt  = look_b_r;
    lit_cnt_nxt = lit_cnt_r;
    plan_new    = '0;
    plan_nxt    = plan_r;
    wr_en       = 1'b0;
    wr_addr     = lit_cnt_r[AW-1:0];
    wr_data     = look_b_r;

    if (in_fire) begin
      if (is_push) begin
        if (run_act_r) begin
          if (b == run_val_r) begin
            if (run_cnt_r + 1'b1 == MAX_C) begin
              // run is full, send it now
              plan_new.repa_v   = 1'b1;
              plan_new.repa_cnt = MAX_C;
              plan_new.repa_val = run_val_r;
              run_act_nxt       = 1'b0;
              run_cnt_nxt       = '0;
            end else begin
              run_cnt_nxt = run_cnt_r + 1'b1;
            end
          end else begin
            // run broken, new byte becomes the lookahead
            plan_new.repa_v   = 1'b1;
            plan_new.repa_cnt = run_cnt_r;
            plan_new.repa_val = run_val_r;
            run_act_nxt       = 1'b0;
            run_cnt_nxt       = '0;
            look_v_nxt        = 1'b1;
            look_b_nxt        = b;
          end
        end else if (look_v_r) begin
          if (b == look_b_r) begin
            // pair found: flush open literal, open a run of two
            if (lit_cnt_r != '0) begin
              plan_new.lit_v = 1'b1;
              plan_new.lit_m = lit_cnt_r;
            end
            lit_cnt_nxt = '0;
            look_v_nxt  = 1'b0;
            run_act_nxt = 1'b1;
            run_val_nxt = b;
            run_cnt_nxt = CW'(2);
            if (MAX_RUN == 2) begin
              plan_new.repb_v   = 1'b1;
              plan_new.repb_cnt = CW'(2);
              plan_new.repb_val = b;
              run_act_nxt       = 1'b0;
              run_cnt_nxt       = '0;
            end
          end else begin
            // lookahead joins the literal
            wr_en = 1'b1;
            if (lit_cnt_r + 1'b1 == MAX_C) begin
              plan_new.lit_v = 1'b1;
              plan_new.lit_m = MAX_C;
              lit_cnt_nxt    = '0;
            end else begin
              lit_cnt_nxt = lit_cnt_r + 1'b1;
            end
            look_b_nxt = b;
          end
        end else begin
          look_v_nxt = 1'b1;
          look_b_nxt = b;
        end
      end

      if (is_close) begin
        if (run_act_nxt) begin
          plan_new.repb_v   = 1'b1;
          plan_new.repb_cnt = run_cnt_nxt;
          plan_new.repb_val = run_val_nxt;
        end
        // the lookahead byte closes the literal straight from a register
        if (look_v_nxt) begin
          plan_new.tail = look_b_nxt;
          if (plan_new.lit_v) begin
            plan_new.lit2_v = 1'b1;
          end else begin
            plan_new.lit_v = 1'b1;
            plan_new.lit_m = lit_cnt_nxt;
            plan_new.lit_t = 1'b1;
          end
        end else if (lit_cnt_nxt != '0) begin
          plan_new.lit_v = 1'b1;
          plan_new.lit_m = lit_cnt_nxt;
        end
        plan_new.end_v = 1'b1;
        run_act_nxt    = 1'b0;
        run_val_nxt    = '0;
        run_cnt_nxt    = '0;
        look_v_nxt     = 1'b0;
        look_b_nxt     = '0;
        lit_cnt_nxt    = '0;
      end
      plan_nxt = plan_new;
    end
  end

  // output side: walk the planned segments one byte per cycle while the packer accepts
  always_comb begin
    after_repb = seg_from(1'b0, 1'b0, 1'b0, 1'b0, plan_r.end_v);
    after_lit2 = seg_from(1'b0, 1'b0, 1'b0, plan_r.repb_v, plan_r.end_v);
    after_lit  = seg_from(1'b0, 1'b0, plan_r.lit2_v, plan_r.repb_v, plan_r.end_v);
    after_repa = seg_from(1'b0, plan_r.lit_v, plan_r.lit2_v, plan_r.repb_v, plan_r.end_v);

    follow        = st_r;
    k_follow      = k_r;
    seq_byte.data = rle_pkg::END_MARKER;
    case (st_r)
      S_REPA_H: begin
        seq_byte.data = 8'(rle_pkg::REP_HDR_BASE - 9'(plan_r.repa_cnt));
        follow        = S_REPA_V;
      end
      S_REPA_V: begin
        seq_byte.data = plan_r.repa_val;
        follow        = after_repa;
      end
      S_LIT_H: begin
        seq_byte.data = 8'(9'(plan_r.lit_m) + 9'(plan_r.lit_t) - 9'd1);
        follow        = (plan_r.lit_m != '0) ? S_LIT_M : S_LIT_T;
        k_follow      = '0;
      end
      S_LIT_M: begin
        seq_byte.data = rd_data;
        if (CW'(k_r) + 1'b1 == plan_r.lit_m) begin
          follow = plan_r.lit_t ? S_LIT_T : after_lit;
        end else begin
          k_follow = k_r + AW'(1);
        end
      end
      S_LIT_T: begin
        seq_byte.data = plan_r.tail;
        follow        = after_lit;
      end
      S_LIT2_H: begin
        seq_byte.data = 8'd0;
        follow        = S_LIT2_T;
      end
      S_LIT2_T: begin
        seq_byte.data = plan_r.tail;
        follow        = after_lit2;
      end
      S_REPB_H: begin
        seq_byte.data = 8'(rle_pkg::REP_HDR_BASE - 9'(plan_r.repb_cnt));
        follow        = S_REPB_V;
      end
      S_REPB_V: begin
        seq_byte.data = plan_r.repb_val;
        follow        = after_repb;
      end
      S_END: begin
        seq_byte.data = rle_pkg::END_MARKER;
        follow        = S_IDLE;
      end
      default: begin
        follow = S_IDLE;
      end
    endcase

    seq_valid         = (st_r != S_IDLE);
    seq_byte.last     = (follow == S_IDLE);
    seq_byte.end_mark = (st_r == S_END);
    emit              = seq_valid && seq_ready;

    if (in_fire) begin
      st_nxt = seg_from(plan_new.repa_v, plan_new.lit_v, plan_new.lit2_v,
                        plan_new.repb_v, plan_new.end_v);
    end else if (emit) begin
      st_nxt = follow;
    end else begin
      st_nxt = st_r;
    end
    k_nxt = emit ? k_follow : k_r;

    // prefetch: entry 0 during the header, the next entry as each one leaves
    rd_en   = (st_r == S_LIT_H) || ((st_r == S_LIT_M) && emit);
    rd_addr = (st_r == S_LIT_H) ? '0 : k_r + AW'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r      <= S_IDLE;
      k_r       <= '0;
      plan_r    <= '0;
      run_act_r <= 1'b0;
      run_val_r <= '0;
      run_cnt_r <= '0;
      look_v_r  <= 1'b0;
      look_b_r  <= '0;
      lit_cnt_r <= '0;
    end else begin
      st_r      <= st_nxt;
      k_r       <= k_nxt;
      plan_r    <= plan_nxt;
      run_act_r <= run_act_nxt;
      run_val_r <= run_val_nxt;
      run_cnt_r <= run_cnt_nxt;
      look_v_r  <= look_v_nxt;
      look_b_r  <= look_b_nxt;
      lit_cnt_r <= lit_cnt_nxt;
    end
  end

  rle_lit_mem #(
    .DEPTH (MAX_RUN),
    .AW    (AW)
  ) u_lit_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  rle_packer u_packer (
    .clk        (clk),
    .rst_n      (rst_n),
    .byte_valid (seq_valid),
    .byte_in    (seq_byte),
    .byte_ready (seq_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

endmodule

// File: src/rle_lit_mem.sv
// literal byte store, one write port and one registered read port
module rle_lit_mem #(
  parameter int DEPTH = 128,
  parameter int AW    = 7
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [7:0]    wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [7:0]    rd_data
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: src/rle_packer.sv
// packs the encoded byte stream into words of up to eight bytes
module rle_packer (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              byte_valid,
  input  rle_pkg::rle_byte_t byte_in,
  output logic              byte_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output rle_pkg::out_t     out_data
);

  logic [2:0]    cnt_r, cnt_nxt;
  logic [63:0]   acc_r, acc_nxt;
  logic [63:0]   word;
  logic          completes;
  logic          fire;
  logic          out_valid_r, out_valid_nxt;
  rle_pkg::out_t out_r, out_nxt;

  always_comb begin
    word = acc_r;
    word[{cnt_r, 3'b000} +: 8] = byte_in.data;
    completes  = byte_in.last || (cnt_r == 3'd7);
    // a byte that closes a word needs the output register free
    byte_ready = !completes || !out_valid_r || out_ready;
    fire       = byte_valid && byte_ready;

    cnt_nxt       = cnt_r;
    acc_nxt       = acc_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (fire) begin
      if (completes) begin
        out_nxt.out_bytes     = word;
        out_nxt.byte_count    = {1'b0, cnt_r} + 4'd1;
        out_nxt.last_of_burst = byte_in.last;
        out_nxt.stream_end    = byte_in.end_mark;
        out_valid_nxt         = 1'b1;
        acc_nxt               = '0;
        cnt_nxt               = '0;
      end else begin
        acc_nxt = word;
        cnt_nxt = cnt_r + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      acc_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r       <= cnt_nxt;
      acc_r       <= acc_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// File: src/rle_checker.sv
// port-level checks on the encoder's output words, bound to the top level
module rle_checker (
  input logic          clk,
  input logic          rst_n,
  input logic          out_valid,
  input logic          out_ready,
  input rle_pkg::out_t out_data
);

  // stalled word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("output word changed while stalled");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.byte_count != 4'd0) && (out_data.byte_count <= 4'd8))
    else $error("byte count out of range");

  a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.stream_end |-> out_data.last_of_burst)
    else $error("end marker word not last of burst");

  // bytes past the count are zero
  a_unused_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.byte_count != 4'd8) |->
      ((out_data.out_bytes >> {out_data.byte_count, 3'b000}) == 64'd0))
    else $error("stray bytes beyond count");

endmodule

bind run_length_byte_encoder rle_checker u_rle_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

// File: tb/sv/run_length_byte_encoder_tb.sv
// self-checking testbench of the run-length byte encoder with its own encoding predictor
module run_length_byte_encoder_tb;

  // close codes; the package only names the two push codes
  localparam logic [1:0] CMD_CLOSE     = 2'd2;
  localparam logic [1:0] CMD_CLOSE_ALT = 2'd3;

  // longest repeat run and deepest literal, as the block is built by default
  localparam int RUN_LIMIT   = 128;
  localparam int STORE_DEPTH = 128;

  // receiver hold-off that backs the block up into its input
  localparam int HOLD_CYCLES = 300;
  // slowest legal run, many times over
  localparam int CYCLE_LIMIT = 400000;
  // quiet time after the last expected word, to catch stray extra words
  localparam int DRAIN_CYCLES = 64;

  typedef enum int {SEG_RUN, SEG_LITERAL, SEG_NOISE} seg_kind_t;
  typedef enum int {STREAM_MIXED, STREAM_LONG_LITERAL} stream_kind_t;

  // encoding predictor and the queue of words it expects, oldest first
  class rle_scoreboard;
    rle_pkg::out_t expected_words[$];
    logic [7:0]    burst[$];
    logic [7:0]    literal_bytes[STORE_DEPTH];
    bit            run_open;
    logic [7:0]    run_byte;
    int            run_len;
    bit            held_valid;
    logic [7:0]    held_byte;
    int            literal_len;
    int            mismatches;

    function new();
      run_open    = 1'b0;
      run_byte    = 8'h00;
      run_len     = 0;
      held_valid  = 1'b0;
      held_byte   = 8'h00;
      literal_len = 0;
      mismatches  = 0;
    endfunction

    function void emit(logic [7:0] v);
      burst.insert(burst.size(), v);
    endfunction

    // repeat segment: header 257 - count, then the byte
    function void flush_run();
      logic [8:0] header;
      header = rle_pkg::REP_HDR_BASE - 9'(run_len);
      emit(header[7:0]);
      emit(run_byte);
      run_open = 1'b0;
      run_len  = 0;
    endfunction

    // literal segment: length - 1, then the stored bytes
    function void flush_literal();
      int i;
      if (literal_len == 0) return;
      emit(8'(literal_len - 1));
      for (i = 0; i < literal_len; i++) emit(literal_bytes[i]);
      literal_len = 0;
    endfunction

    function void store_literal(logic [7:0] v);
      if (literal_len < STORE_DEPTH) begin
        literal_bytes[literal_len] = v;
        literal_len++;
      end
    endfunction

    function void push_byte(logic [7:0] b);
      if (run_open) begin
        if (b == run_byte && run_len < RUN_LIMIT) begin
          run_len++;
          if (run_len >= RUN_LIMIT) flush_run();
        end else begin
          // run broken: the new byte becomes the lookahead
          flush_run();
          held_valid = 1'b1;
          held_byte  = b;
        end
      end else if (held_valid) begin
        if (b == held_byte) begin
          // two equal bytes open a run, pending literal goes out first
          flush_literal();
          held_valid = 1'b0;
          run_open   = 1'b1;
          run_byte   = b;
          run_len    = 2;
          if (run_len >= RUN_LIMIT) flush_run();
        end else begin
          store_literal(held_byte);
          if (literal_len >= RUN_LIMIT) flush_literal();
          held_byte = b;
        end
      end else begin
        held_valid = 1'b1;
        held_byte  = b;
      end
    endfunction

    function void close_stream();
      if (run_open) flush_run();
      if (held_valid) begin
        store_literal(held_byte);
        held_valid = 1'b0;
      end
      flush_literal();
      emit(rle_pkg::END_MARKER);
      run_open    = 1'b0;
      run_byte    = 8'h00;
      run_len     = 0;
      held_byte   = 8'h00;
      literal_len = 0;
    endfunction

    // predict the words one accepted input word causes
    function void take_input(rle_pkg::in_t w);
      bit            closing;
      int            n_words;
      int            n_bytes;
      int            k;
      int            i;
      rle_pkg::out_t word;
      burst.delete();
      closing = (w.cmd != rle_pkg::CMD_PUSH);
      if (w.cmd == rle_pkg::CMD_PUSH || w.cmd == rle_pkg::CMD_PUSH_CLOSE)
        push_byte(w.data_byte);
      if (closing) close_stream();
      n_words = (burst.size() + 7) / 8;
      for (k = 0; k < n_words; k++) begin
        n_bytes = burst.size() - 8 * k;
        if (n_bytes > 8) n_bytes = 8;
        word = '0;
        for (i = 0; i < n_bytes; i++) word.out_bytes[8*i +: 8] = burst[8*k + i];
        word.byte_count    = 4'(n_bytes);
        word.last_of_burst = (k == n_words - 1);
        word.stream_end    = closing && (k == n_words - 1);
        expected_words.insert(expected_words.size(), word);
      end
    endfunction

    function void report(string what, rle_pkg::out_t exp_w, rle_pkg::out_t got);
      mismatches++;
      if (mismatches <= 10)
        $display("%s: expected %h cnt %0d last %0b end %0b, got %h cnt %0d last %0b end %0b",
                 what, exp_w.out_bytes, exp_w.byte_count, exp_w.last_of_burst,
                 exp_w.stream_end, got.out_bytes, got.byte_count, got.last_of_burst,
                 got.stream_end);
    endfunction

    function void check_output(rle_pkg::out_t got);
      rle_pkg::out_t exp_w;
      if (expected_words.size() == 0) begin
        report("unexpected word", '0, got);
        return;
      end
      exp_w = expected_words.pop_front();
      if (got.out_bytes !== exp_w.out_bytes || got.byte_count !== exp_w.byte_count ||
          got.last_of_burst !== exp_w.last_of_burst || got.stream_end !== exp_w.stream_end)
        report("wrong word", exp_w, got);
    endfunction

    function void flag_leftovers();
      while (expected_words.size() != 0)
        report("missing word", expected_words.pop_front(), '0);
    endfunction

    function int pending();
      return expected_words.size();
    endfunction
  endclass

  logic          clk = 1'b0;
  logic          rst_n;
  logic          in_valid;
  logic          in_ready;
  rle_pkg::in_t  in_data;
  logic          out_valid;
  logic          out_ready;
  rle_pkg::out_t out_data;

  rle_scoreboard scoreboard = new();

  // idle odds in percent, set per phase by the stimulus
  int in_idle_pct  = 0;
  int out_idle_pct = 0;
  int words_sent   = 0;
  int cycle_count  = 0;
  logic [7:0] last_sent = 8'h00;

  // hold-off request: the stimulus toggles it, the receiver notices the change
  bit hold_req  = 1'b0;
  bit hold_seen = 1'b0;
  int hold_left = 0;

  run_length_byte_encoder dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always #10 clk = ~clk;

  // watchdog, counts every cycle of the run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("run_length_byte_encoder: mismatch");
      $finish;
    end
  end

  // receiver: random ready at the falling edge, or a long hold when asked
  always @(negedge clk) begin
    if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= out_idle_pct);
    end
  end

  // every accepted output word is checked against the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) scoreboard.check_output(out_data);
  end

  // offer one input word and wait for its handshake; valid stays high between
  // back-to-back words, so it is only lowered when the sender idles
  task automatic send_word(input logic [1:0] cmd, input logic [7:0] b);
    rle_pkg::in_t w;
    w.cmd       = cmd;
    w.data_byte = b;
    @(negedge clk);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    scoreboard.take_input(w);
    words_sent++;
    if (cmd == rle_pkg::CMD_PUSH || cmd == rle_pkg::CMD_PUSH_CLOSE) last_sent = b;
  endtask

  // half the bytes from a few corner values, so repeats also show up by chance
  function automatic logic [7:0] pick_byte();
    if ($urandom_range(1) == 0) return 8'($urandom);
    case ($urandom_range(3))
      0:       return 8'h00;
      1:       return 8'hFF;
      2:       return 8'h80;
      default: return 8'h7F;
    endcase
  endfunction

  task automatic send_segment(input seg_kind_t kind, input int len);
    logic [7:0] v;
    case (kind)
      SEG_RUN: begin
        v = pick_byte();
        repeat (len) send_word(rle_pkg::CMD_PUSH, v);
      end
      SEG_LITERAL: begin
        // adjacent bytes differ, so the literal grows without starting a run
        repeat (len) begin
          v = pick_byte();
          while (v == last_sent) v = pick_byte();
          send_word(rle_pkg::CMD_PUSH, v);
        end
      end
      default: begin
        // noise: any command, any byte
        repeat (len) send_word(2'($urandom_range(3)), 8'($urandom));
      end
    endcase
  endtask

  // one stream of runs, literals and noise, mostly closed in one of the three ways
  task automatic send_stream(input stream_kind_t kind);
    int        n_seg;
    int        pick;
    int        len;
    seg_kind_t seg;
    n_seg = $urandom_range(1, 5);
    if (kind == STREAM_LONG_LITERAL)
      send_segment(SEG_LITERAL, $urandom_range(RUN_LIMIT + 1, RUN_LIMIT + 3));
    repeat (n_seg) begin
      pick = $urandom_range(99);
      seg  = (pick < 45) ? SEG_RUN : (pick < 88) ? SEG_LITERAL : SEG_NOISE;
      len  = ($urandom_range(99) < 85) ? $urandom_range(1, 6) : $urandom_range(7, 40);
      if (seg == SEG_RUN && len < 2) len = 2;
      send_segment(seg, len);
    end
    pick = $urandom_range(99);
    if (pick < 45)      send_word(rle_pkg::CMD_PUSH_CLOSE, pick_byte());
    else if (pick < 75) send_word(CMD_CLOSE, 8'($urandom));
    else if (pick < 90) send_word(CMD_CLOSE_ALT, 8'($urandom));
  endtask

  // corners: empty streams, both close codes, run after a literal, broken run,
  // push-and-close on a fresh stream, ignored byte on close
  task automatic send_directed();
    send_word(CMD_CLOSE, 8'h00);
    send_word(CMD_CLOSE_ALT, 8'hFF);
    send_word(rle_pkg::CMD_PUSH, 8'h00);
    send_word(rle_pkg::CMD_PUSH, 8'hFF);
    send_word(rle_pkg::CMD_PUSH, 8'hFF);
    send_word(rle_pkg::CMD_PUSH, 8'hFF);
    send_word(rle_pkg::CMD_PUSH, 8'h00);
    send_word(rle_pkg::CMD_PUSH_CLOSE, 8'h00);
    send_word(rle_pkg::CMD_PUSH, 8'h55);
    send_word(rle_pkg::CMD_PUSH_CLOSE, 8'hAA);
    send_word(rle_pkg::CMD_PUSH, 8'h12);
    send_word(CMD_CLOSE, 8'hFF);
    send_word(rle_pkg::CMD_PUSH, 8'hA5);
    send_word(rle_pkg::CMD_PUSH, 8'h5A);
    send_word(rle_pkg::CMD_PUSH, 8'hA5);
    send_word(CMD_CLOSE_ALT, 8'h5A);
    send_word(rle_pkg::CMD_PUSH_CLOSE, 8'h7F);
    send_word(rle_pkg::CMD_PUSH, 8'h80);
    send_word(rle_pkg::CMD_PUSH, 8'h80);
    send_word(rle_pkg::CMD_PUSH, 8'h80);
    send_word(CMD_CLOSE, 8'h80);
  endtask

  initial begin
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    out_ready = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // phase one: sender idles a quarter of the time, receiver most of it
    in_idle_pct  = 25;
    out_idle_pct = 69;
    send_directed();
    while (words_sent < 55) send_stream(STREAM_MIXED);

    // phase two: the other way round, with a literal that fills the store
    in_idle_pct  = 69;
    out_idle_pct = 25;
    send_stream(STREAM_LONG_LITERAL);

    // phase three: full rate; the receiver holds off first so the block backs up
    in_idle_pct  = 0;
    out_idle_pct = 0;
    hold_req     = ~hold_req;
    do send_stream(STREAM_MIXED); while (words_sent < 225);

    @(negedge clk);
    in_valid <= 1'b0;
    while (scoreboard.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    scoreboard.flag_leftovers();
    if (scoreboard.mismatches == 0) begin
      $display("run_length_byte_encoder: match");
    end else begin
      $display("run_length_byte_encoder: mismatch");
    end
    $finish;
  end

endmodule

// File: files.f
src/rle_pkg.sv
src/rle_lit_mem.sv
src/rle_packer.sv
src/run_length_byte_encoder.sv
src/rle_checker.sv
tb/sv/run_length_byte_encoder_tb.sv
